>>> sv/straight_line_waypoint_interpolator_top_defines.svh
// Assertion macros shared by the waypoint interpolator RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef STRAIGHT_LINE_WAYPOINT_INTERPOLATOR_TOP_DEFINES_SVH
`define STRAIGHT_LINE_WAYPOINT_INTERPOLATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SLWI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SLWI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/slwi_pkg.sv
package slwi_pkg;

  // Coordinate width of every point field.
  localparam int CW = 24;
  // Magnitude width: one bit more than a coordinate, so that the root and
  // the differences share one iteration count.
  localparam int MW = CW + 1;
  // Width of a sum of two squares of magnitudes.
  localparam int SW = 2 * MW;
  // Width of the step resolution register.
  localparam int RES_W = 16;
  // Iteration counter width for the serial units.
  localparam int CNT_W = $clog2(MW);
  // Reset value of the step resolution register (26 coordinate units).
  localparam logic [RES_W-1:0] RES_RESET = RES_W'(26);

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] goal_x;
    logic signed [CW-1:0] goal_y;
  } req_t;

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic                 last_point;
  } wpt_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQUARE,
    S_SUM,
    S_ROOT,
    S_DIVN,
    S_CLAMP,
    S_DIVD,
    S_EMIT,
    S_GOAL
  } state_t;

endpackage

>>> sv/straight_line_waypoint_interpolator_top.sv
// A request whose start equals its goal goes straight to the goal state for its single beat.
// Otherwise the first waypoint waits for four serial units that run one after another.
// Those are shift-add squaring, a two-bit-a-cycle root, and two one-bit-a-cycle dividers.
// Then one waypoint beat per cycle follows while the sink takes them, n beats plus the goal.
// A new request is taken only after the goal beat of the last one has been registered.
// Reset (synchronous, active high) idles the block, empties the output and sets resolution to 26.
`include "straight_line_waypoint_interpolator_top_defines.svh"

// Straight-line waypoint interpolator.
//
// A request carries a start and a goal point. The block finds the distance
// between them with a bit-serial square and root, divides it by the step
// resolution to get the step count n (at least one, at most MAX_STEPS), and
// then walks from the start toward the goal. Each axis offset d*i/n is kept
// as a running quotient and remainder: per step the quotient grows by d/n and
// the remainder by d mod n, with a carry when the remainder reaches n. That
// keeps the emit loop to one narrow add and compare per axis per beat.
//
// All of the heavy arithmetic runs in shift registers, one or two bits per
// cycle, so the logic between registers stays about one word wide.
//
// The output beat sits in a register, so the block goes back to idle and
// takes the next request while the goal beat of the last one still waits.
module straight_line_waypoint_interpolator_top import slwi_pkg::*; #(
  parameter int MAX_STEPS = 63
) (
  input  logic             clk,
  input  logic             rst,
  // Step resolution register write.
  input  logic             cfg_wen,
  input  logic [RES_W-1:0] cfg_wdata,
  // Request channel.
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req_data,
  // Waypoint channel.
  output logic             wpt_valid,
  input  logic             wpt_ready,
  output wpt_t             wpt_data
);

  // Width of the step count and of the remainders modulo it.
  localparam int NW = $clog2(MAX_STEPS + 1);

  state_t state, state_next;

  // Configuration.
  logic [RES_W-1:0] step_resolution;

  // Captured request.
  logic signed [CW-1:0] sx, sy, gx, gy;
  logic                 negx, negy;
  logic [MW-1:0]        ax, ay;

  // Shared iteration counter for the serial units.
  logic [CNT_W-1:0] cnt;

  // Squaring: multiplier bits shift out at the bottom, the multiplicand
  // shifts up, and the partial products collect in the accumulators. In the
  // axis division the multiplier registers hold dividend and quotient.
  logic [MW-1:0] mplx, mply;
  logic [SW-1:0] mcx, mcy;
  logic [SW-1:0] sqx, sqy;

  // Root: the radicand shifts out two bits a cycle. The root register then
  // serves as dividend and quotient for the step count division.
  logic [SW-1:0] rad;
  logic [MW:0]   rem;
  logic [MW-1:0] root;
  logic [RES_W-1:0] nrem;

  // Step count and per-step quotient and remainder of each axis.
  logic [NW-1:0] nstep;
  logic [NW-1:0] remx, remy;
  logic [MW-1:0] qstepx, qstepy;
  logic [NW-1:0] rstepx, rstepy;

  // Running offsets along each axis and the waypoint index.
  logic [MW-1:0] accx, accy;
  logic [NW-1:0] accrx, accry;
  logic [NW-1:0] idx;

  // Handshake and control.
  logic slot_free;
  logic req_fire;
  logic emit_fire;
  logic goal_fire;
  logic last_iter;
  logic last_emit;
  logic same_point;

  // Combinational step values.
  logic signed [MW-1:0] dx_new, dy_new;
  logic [MW+2:0]  remsh, trial, rem_sub;
  logic           root_ge;
  logic [RES_W:0] dt, dsub;
  logic           dge;
  logic [NW:0]    xt, yt, xsub, ysub;
  logic           xge, yge;
  logic [NW:0]    sumrx, sumry, wsubx, wsuby;
  logic           wrapx, wrapy;
  logic [MW:0]    offx, offy, pxw, pyw;
  logic [NW-1:0]  nclamp;

  // -----------------------------------------------------------------------
  // Step logic of the serial units.
  // -----------------------------------------------------------------------
  always_comb begin
    // Differences of the incoming request, which always fit MW bits.
    dx_new = MW'(req_data.goal_x) - MW'(req_data.start_x);
    dy_new = MW'(req_data.goal_y) - MW'(req_data.start_y);
    same_point = (req_data.start_x == req_data.goal_x) &&
                 (req_data.start_y == req_data.goal_y);

    // Restoring square root, two radicand bits per step.
    remsh   = {rem, rad[SW-1 -: 2]};
    trial   = {1'b0, root, 2'b01};
    root_ge = (remsh >= trial);
    rem_sub = remsh - trial;

    // Distance divided by the resolution, one quotient bit per step. A zero
    // resolution yields an all-ones quotient, which saturates below.
    dt   = {nrem, root[MW-1]};
    dge  = (dt >= {1'b0, step_resolution});
    dsub = dt - {1'b0, step_resolution};

    // Axis magnitudes divided by the step count.
    xt   = {remx, mplx[MW-1]};
    yt   = {remy, mply[MW-1]};
    xge  = (xt >= {1'b0, nstep});
    yge  = (yt >= {1'b0, nstep});
    xsub = xt - {1'b0, nstep};
    ysub = yt - {1'b0, nstep};

    // Step count clamped to one through MAX_STEPS.
    if (root == '0) begin
      nclamp = NW'(1);
    end else if (root > MW'(MAX_STEPS)) begin
      nclamp = NW'(MAX_STEPS);
    end else begin
      nclamp = root[NW-1:0];
    end

    // Remainder carry of the running offsets.
    sumrx = {1'b0, accrx} + {1'b0, rstepx};
    sumry = {1'b0, accry} + {1'b0, rstepy};
    wrapx = (sumrx >= {1'b0, nstep});
    wrapy = (sumry >= {1'b0, nstep});
    wsubx = sumrx - {1'b0, nstep};
    wsuby = sumry - {1'b0, nstep};

    // Waypoint: start plus the signed offset.
    offx = negx ? (~{1'b0, accx} + (MW+1)'(1)) : {1'b0, accx};
    offy = negy ? (~{1'b0, accy} + (MW+1)'(1)) : {1'b0, accy};
    pxw  = {{(MW+1-CW){sx[CW-1]}}, sx} + offx;
    pyw  = {{(MW+1-CW){sy[CW-1]}}, sy} + offy;
  end

  // -----------------------------------------------------------------------
  // Control outputs.
  // -----------------------------------------------------------------------
  always_comb begin
    slot_free = !wpt_valid || wpt_ready;
    req_ready = (state == S_IDLE);
    req_fire  = req_valid && req_ready;
    emit_fire = (state == S_EMIT) && slot_free;
    goal_fire = (state == S_GOAL) && slot_free;
    last_iter = (cnt == CNT_W'(MW - 1));
    last_emit = (idx == nstep - NW'(1));
  end

  // -----------------------------------------------------------------------
  // Next state.
  // -----------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          state_next = same_point ? S_GOAL : S_SQUARE;
        end
      end
      S_SQUARE: begin
        if (last_iter) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        state_next = S_ROOT;
      end
      S_ROOT: begin
        if (last_iter) begin
          state_next = S_DIVN;
        end
      end
      S_DIVN: begin
        if (last_iter) begin
          state_next = S_CLAMP;
        end
      end
      S_CLAMP: begin
        state_next = S_DIVD;
      end
      S_DIVD: begin
        if (last_iter) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_fire && last_emit) begin
          state_next = S_GOAL;
        end
      end
      S_GOAL: begin
        if (goal_fire) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // -----------------------------------------------------------------------
  // Control registers.
  // -----------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      wpt_valid       <= 1'b0;
      step_resolution <= RES_RESET;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        step_resolution <= cfg_wdata;
      end
      if (emit_fire || goal_fire) begin
        wpt_valid <= 1'b1;
      end else if (wpt_ready) begin
        wpt_valid <= 1'b0;
      end
    end
  end

  // -----------------------------------------------------------------------
  // Datapath registers.
  // -----------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cnt <= '0;
        if (req_fire) begin
          sx   <= req_data.start_x;
          sy   <= req_data.start_y;
          gx   <= req_data.goal_x;
          gy   <= req_data.goal_y;
          negx <= dx_new[MW-1];
          negy <= dy_new[MW-1];
          ax   <= dx_new[MW-1] ? (~dx_new + MW'(1)) : dx_new;
          ay   <= dy_new[MW-1] ? (~dy_new + MW'(1)) : dy_new;
          mplx <= dx_new[MW-1] ? (~dx_new + MW'(1)) : dx_new;
          mply <= dy_new[MW-1] ? (~dy_new + MW'(1)) : dy_new;
          mcx  <= {{(SW-MW){1'b0}}, dx_new[MW-1] ? (~dx_new + MW'(1)) : dx_new};
          mcy  <= {{(SW-MW){1'b0}}, dy_new[MW-1] ? (~dy_new + MW'(1)) : dy_new};
          sqx  <= '0;
          sqy  <= '0;
        end
      end
      S_SQUARE: begin
        cnt  <= last_iter ? '0 : cnt + CNT_W'(1);
        sqx  <= sqx + (mplx[0] ? mcx : '0);
        sqy  <= sqy + (mply[0] ? mcy : '0);
        mcx  <= {mcx[SW-2:0], 1'b0};
        mcy  <= {mcy[SW-2:0], 1'b0};
        mplx <= {1'b0, mplx[MW-1:1]};
        mply <= {1'b0, mply[MW-1:1]};
      end
      S_SUM: begin
        rad  <= sqx + sqy;
        rem  <= '0;
        root <= '0;
      end
      S_ROOT: begin
        cnt  <= last_iter ? '0 : cnt + CNT_W'(1);
        rad  <= {rad[SW-3:0], 2'b00};
        rem  <= root_ge ? rem_sub[MW:0] : remsh[MW:0];
        root <= {root[MW-2:0], root_ge};
        nrem <= '0;
      end
      S_DIVN: begin
        cnt  <= last_iter ? '0 : cnt + CNT_W'(1);
        nrem <= dge ? dsub[RES_W-1:0] : dt[RES_W-1:0];
        root <= {root[MW-2:0], dge};
      end
      S_CLAMP: begin
        nstep <= nclamp;
        mplx  <= ax;
        mply  <= ay;
        remx  <= '0;
        remy  <= '0;
        accx  <= '0;
        accy  <= '0;
        accrx <= '0;
        accry <= '0;
        idx   <= '0;
      end
      S_DIVD: begin
        cnt  <= last_iter ? '0 : cnt + CNT_W'(1);
        remx <= xge ? xsub[NW-1:0] : xt[NW-1:0];
        remy <= yge ? ysub[NW-1:0] : yt[NW-1:0];
        mplx <= {mplx[MW-2:0], xge};
        mply <= {mply[MW-2:0], yge};
        if (last_iter) begin
          // The final quotient bit and remainder land here.
          qstepx <= {mplx[MW-2:0], xge};
          qstepy <= {mply[MW-2:0], yge};
          rstepx <= xge ? xsub[NW-1:0] : xt[NW-1:0];
          rstepy <= yge ? ysub[NW-1:0] : yt[NW-1:0];
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          wpt_data.point_x    <= pxw[CW-1:0];
          wpt_data.point_y    <= pyw[CW-1:0];
          wpt_data.last_point <= 1'b0;
          accrx <= wrapx ? wsubx[NW-1:0] : sumrx[NW-1:0];
          accry <= wrapy ? wsuby[NW-1:0] : sumry[NW-1:0];
          accx  <= accx + qstepx + MW'(wrapx);
          accy  <= accy + qstepy + MW'(wrapy);
          idx   <= idx + NW'(1);
        end
      end
      S_GOAL: begin
        if (goal_fire) begin
          wpt_data.point_x    <= gx;
          wpt_data.point_y    <= gy;
          wpt_data.last_point <= 1'b1;
        end
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

  // -----------------------------------------------------------------------
  // Checks.
  // -----------------------------------------------------------------------
  `SLWI_ASSERT_NOW(a_nstep_range, state == S_EMIT, (nstep != '0) && (nstep <= NW'(MAX_STEPS)), "step count out of range")
  `SLWI_ASSERT_NOW(a_rem_below_n, state == S_EMIT, (accrx < nstep) && (accry < nstep), "offset remainder reached the step count")
  `SLWI_ASSERT_NEXT(a_goal_beat, goal_fire, wpt_valid && wpt_data.last_point && (wpt_data.point_x == $past(gx)) && (wpt_data.point_y == $past(gy)), "goal beat wrong")
  `SLWI_ASSERT_NEXT(a_emit_not_last, emit_fire, wpt_valid && !wpt_data.last_point, "interior waypoint marked last")

endmodule
